// ===== rtl/rss_pkg.sv =====
// Shared widths, constants and sequencer states for the running sample statistics block.
package rss_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int COUNT_W     = 21;
  localparam int SUM_W       = 37;
  localparam int SUMSQ_W     = 52;
  localparam int MEAN_W      = 24;
  localparam int DEV_W       = 23;

  // Q.8 scaling of the mean, and its square for the deviation radicand
  localparam int MEAN_SHIFT  = 8;
  localparam int DEV_SHIFT   = 2 * MEAN_SHIFT;

  // shared add/subtract unit and the operands that pass through it
  localparam int ALU_W       = 88;
  localparam int MAG_W       = 36;
  localparam int MCAND_W     = 72;
  localparam int QUO_W       = 44;
  localparam int DIV_REM_W   = COUNT_W;
  localparam int SQ_REM_W    = 48;
  localparam int CNT_W       = 6;

  localparam int DIV_STEPS   = QUO_W;
  localparam int MULQ_STEPS  = COUNT_W;
  localparam int MULS_STEPS  = MAG_W;
  localparam int SQRT_STEPS  = ALU_W / 2;

  localparam logic [COUNT_W-1:0] MAX_SAMPLES = COUNT_W'(1048576);

  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ACC,
    ST_LOAD,
    ST_DIVM,
    ST_MULQ,
    ST_MULS,
    ST_SQRT,
    ST_DIVD,
    ST_DONE
  } state_t;

endpackage

// ===== rtl/running_sample_statistics.sv =====
// Running count, mean, deviation, minimum and maximum over a stream of signed samples.
//
//   channel | signals                                   | carries
//   --------+-------------------------------------------+---------------------------------
//   sample  | sample_valid, sample_stall, sample        | one signed sample per transaction
//   result  | result_valid, result_stall, sample_count, | updated statistics, one per
//           | mean_q8, stddev_q8, largest, smallest,    | accepted sample
//           | full_res                                  |
//
// A new sample is taken only in idle, after the previous result has been registered.
// Each update is sequenced through the single 88-bit add/subtract unit: 44 steps of
// mean division, 21 + 36 shift-add multiply steps, 44 square root steps and 44 steps
// of deviation division.
// rst is synchronous, clears the statistics and result_valid and returns the sequencer to idle.
// sample_stall is high from acceptance until the sequencer is back in idle; a held result
// delays the return to idle but a waiting result does not block the next sample.
module running_sample_statistics (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                sample_valid,
  output logic                                sample_stall,
  input  logic signed [rss_pkg::SAMPLE_BITS-1:0] sample,
  output logic                                result_valid,
  input  logic                                result_stall,
  output logic [rss_pkg::COUNT_W-1:0]         sample_count,
  output logic signed [rss_pkg::MEAN_W-1:0]   mean_q8,
  output logic [rss_pkg::DEV_W-1:0]           stddev_q8,
  output logic signed [rss_pkg::SAMPLE_BITS-1:0] largest,
  output logic signed [rss_pkg::SAMPLE_BITS-1:0] smallest,
  output logic                                full_res
);

  rss_pkg::state_t state, state_next;

  logic [rss_pkg::COUNT_W-1:0]            count;
  logic signed [rss_pkg::SUM_W-1:0]       sum;
  logic [rss_pkg::SUMSQ_W-1:0]            sumsq;
  logic signed [rss_pkg::SAMPLE_BITS-1:0] maxv;
  logic signed [rss_pkg::SAMPLE_BITS-1:0] minv;
  logic signed [rss_pkg::SAMPLE_BITS-1:0] sample_q;
  logic                                   full;

  logic [rss_pkg::CNT_W-1:0]     cnt;
  logic [rss_pkg::ALU_W-1:0]     acc;
  logic [rss_pkg::MCAND_W-1:0]   mcand;
  logic [rss_pkg::MAG_W-1:0]     mplier;
  logic [rss_pkg::QUO_W-1:0]     quo;
  logic [rss_pkg::SQ_REM_W-1:0]  rem;
  logic                          neg;
  logic [rss_pkg::MEAN_W-1:0]    mean_hold;

  logic signed [2*rss_pkg::SAMPLE_BITS-1:0] sq;
  logic [rss_pkg::SUM_W-1:0]     sum_abs;
  logic [rss_pkg::MAG_W-1:0]     smag;
  logic [rss_pkg::DIV_REM_W:0]   div_sh;
  logic [rss_pkg::SQ_REM_W-1:0]  sqrt_sh;
  logic [rss_pkg::ALU_W-1:0]     alu_a;
  logic [rss_pkg::ALU_W-1:0]     alu_b;
  logic                          alu_sub;
  logic [rss_pkg::ALU_W:0]       alu_res;
  logic                          carry;
  logic [rss_pkg::ALU_W-1:0]     acc_step;
  logic [rss_pkg::QUO_W-1:0]     q_final;
  logic [rss_pkg::MEAN_W-1:0]    mean_mag;
  logic [rss_pkg::MEAN_W-1:0]    mean_val;
  logic                          last;
  logic                          out_free;

  assign sq      = sample_q * sample_q;
  assign sum_abs = sum[rss_pkg::SUM_W-1] ? -sum : sum;
  assign smag    = sum_abs[rss_pkg::MAG_W-1:0];
  assign div_sh  = {rem[rss_pkg::DIV_REM_W-1:0], quo[rss_pkg::QUO_W-1]};
  assign sqrt_sh = {rem[rss_pkg::SQ_REM_W-3:0], acc[rss_pkg::ALU_W-1 -: 2]};
  assign last    = (cnt == '0);
  assign out_free = !result_valid || !result_stall;

  // shared add/subtract unit: carry out on subtract means a >= b
  always_comb begin
    alu_a   = acc;
    alu_b   = '0;
    alu_sub = 1'b0;
    case (state)
      rss_pkg::ST_DIVM, rss_pkg::ST_DIVD: begin
        alu_a   = rss_pkg::ALU_W'(div_sh);
        alu_b   = rss_pkg::ALU_W'(count);
        alu_sub = 1'b1;
      end
      rss_pkg::ST_MULQ: begin
        alu_a   = acc;
        alu_b   = rss_pkg::ALU_W'(mcand);
        alu_sub = 1'b0;
      end
      rss_pkg::ST_MULS: begin
        alu_a   = acc;
        alu_b   = rss_pkg::ALU_W'(mcand);
        alu_sub = 1'b1;
      end
      rss_pkg::ST_SQRT: begin
        alu_a   = rss_pkg::ALU_W'(sqrt_sh);
        alu_b   = rss_pkg::ALU_W'({quo, 2'b01});
        alu_sub = 1'b1;
      end
      default: begin
        alu_a   = acc;
        alu_b   = '0;
        alu_sub = 1'b0;
      end
    endcase
  end

  assign alu_res  = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)}
                  + (rss_pkg::ALU_W+1)'(alu_sub);
  assign carry    = alu_res[rss_pkg::ALU_W];
  assign acc_step = mplier[0] ? alu_res[rss_pkg::ALU_W-1:0] : acc;
  assign q_final  = {quo[rss_pkg::QUO_W-2:0], carry};
  assign mean_mag = q_final[rss_pkg::MEAN_W-1:0];
  assign mean_val = neg ? -mean_mag : mean_mag;

  always_comb begin
    state_next   = state;
    sample_stall = (state != rss_pkg::ST_IDLE);
    case (state)
      rss_pkg::ST_IDLE: if (sample_valid) state_next = rss_pkg::ST_ACC;
      rss_pkg::ST_ACC:  state_next = rss_pkg::ST_LOAD;
      rss_pkg::ST_LOAD: state_next = rss_pkg::ST_DIVM;
      rss_pkg::ST_DIVM: if (last) state_next = rss_pkg::ST_MULQ;
      rss_pkg::ST_MULQ: if (last) state_next = rss_pkg::ST_MULS;
      rss_pkg::ST_MULS: if (last) state_next = rss_pkg::ST_SQRT;
      rss_pkg::ST_SQRT: if (last) state_next = rss_pkg::ST_DIVD;
      rss_pkg::ST_DIVD: if (last) state_next = rss_pkg::ST_DONE;
      rss_pkg::ST_DONE: if (out_free) state_next = rss_pkg::ST_IDLE;
      default:          state_next = rss_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rss_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // statistics and result handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      count        <= '0;
      sum          <= '0;
      sumsq        <= '0;
      maxv         <= rss_pkg::SAMPLE_MIN;
      minv         <= rss_pkg::SAMPLE_MAX;
      result_valid <= 1'b0;
    end else begin
      if (state == rss_pkg::ST_ACC) begin
        if (count == rss_pkg::MAX_SAMPLES) begin
          full <= 1'b1;
        end else begin
          full  <= 1'b0;
          count <= count + rss_pkg::COUNT_W'(1);
          sum   <= sum + rss_pkg::SUM_W'(sample_q);
          sumsq <= sumsq + rss_pkg::SUMSQ_W'($unsigned(sq));
          if (sample_q > maxv) maxv <= sample_q;
          if (sample_q < minv) minv <= sample_q;
        end
      end
      if (state == rss_pkg::ST_DONE && out_free) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // sequenced datapath around the shared unit
  always_ff @(posedge clk) begin
    case (state)
      rss_pkg::ST_IDLE: begin
        if (sample_valid) sample_q <= sample;
      end
      rss_pkg::ST_LOAD: begin
        rem <= '0;
        quo <= {smag, {rss_pkg::MEAN_SHIFT{1'b0}}};
        neg <= sum[rss_pkg::SUM_W-1];
        cnt <= rss_pkg::CNT_W'(rss_pkg::DIV_STEPS - 1);
      end
      rss_pkg::ST_DIVM: begin
        rem <= rss_pkg::SQ_REM_W'(carry ? alu_res[rss_pkg::DIV_REM_W-1:0]
                                        : div_sh[rss_pkg::DIV_REM_W-1:0]);
        quo <= q_final;
        cnt <= cnt - rss_pkg::CNT_W'(1);
        if (last) begin
          mean_hold <= mean_val;
          acc       <= '0;
          mcand     <= rss_pkg::MCAND_W'(sumsq);
          mplier    <= rss_pkg::MAG_W'(count);
          cnt       <= rss_pkg::CNT_W'(rss_pkg::MULQ_STEPS - 1);
        end
      end
      rss_pkg::ST_MULQ: begin
        acc    <= acc_step;
        mcand  <= mcand << 1;
        mplier <= mplier >> 1;
        cnt    <= cnt - rss_pkg::CNT_W'(1);
        if (last) begin
          mcand  <= rss_pkg::MCAND_W'(smag);
          mplier <= smag;
          cnt    <= rss_pkg::CNT_W'(rss_pkg::MULS_STEPS - 1);
        end
      end
      rss_pkg::ST_MULS: begin
        acc    <= acc_step;
        mcand  <= mcand << 1;
        mplier <= mplier >> 1;
        cnt    <= cnt - rss_pkg::CNT_W'(1);
        if (last) begin
          // drop a negative difference, else scale the radicand by 2^16
          acc <= acc_step[rss_pkg::ALU_W-1] ? '0
               : {acc_step[rss_pkg::ALU_W-rss_pkg::DEV_SHIFT-1:0],
                  {rss_pkg::DEV_SHIFT{1'b0}}};
          rem <= '0;
          quo <= '0;
          cnt <= rss_pkg::CNT_W'(rss_pkg::SQRT_STEPS - 1);
        end
      end
      rss_pkg::ST_SQRT: begin
        rem <= carry ? alu_res[rss_pkg::SQ_REM_W-1:0] : sqrt_sh;
        quo <= q_final;
        acc <= acc << 2;
        cnt <= cnt - rss_pkg::CNT_W'(1);
        if (last) begin
          rem <= '0;
          cnt <= rss_pkg::CNT_W'(rss_pkg::DIV_STEPS - 1);
        end
      end
      rss_pkg::ST_DIVD: begin
        rem <= rss_pkg::SQ_REM_W'(carry ? alu_res[rss_pkg::DIV_REM_W-1:0]
                                        : div_sh[rss_pkg::DIV_REM_W-1:0]);
        quo <= q_final;
        cnt <= cnt - rss_pkg::CNT_W'(1);
      end
      rss_pkg::ST_DONE: begin
        if (out_free) begin
          sample_count <= count;
          mean_q8      <= mean_hold;
          stddev_q8    <= quo[rss_pkg::DEV_W-1:0];
          largest      <= maxv;
          smallest     <= minv;
          full_res     <= full;
        end
      end
      default: begin
      end
    endcase
  end

`ifndef SYNTHESIS
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (sample_valid && !sample_stall) |=> (state == rss_pkg::ST_ACC))
    else $error("accepted sample did not start the update");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> ($past(state) == rss_pkg::ST_DONE))
    else $error("result raised outside the final step");

  a_full_at_limit: assert property (@(posedge clk) disable iff (rst)
    (result_valid && full_res) |-> (sample_count == rss_pkg::MAX_SAMPLES))
    else $error("full flag set below the sample limit");

  a_min_below_max: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (smallest <= largest))
    else $error("minimum above maximum in a result");
`endif

endmodule

// ===== sim/tb_running_sample_statistics.sv =====
// Self-checking testbench for the running sample statistics block.
module tb_running_sample_statistics;

  localparam int HOLDOFF_CYCLES = 600;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 250;

  typedef struct {
    logic [rss_pkg::COUNT_W-1:0]            count;
    logic signed [rss_pkg::MEAN_W-1:0]      mean;
    logic [rss_pkg::DEV_W-1:0]              dev;
    logic signed [rss_pkg::SAMPLE_BITS-1:0] largest;
    logic signed [rss_pkg::SAMPLE_BITS-1:0] smallest;
    logic                                   full;
  } stats_t;

  logic                                   clk = 1'b0;
  logic                                   rst = 1'b1;
  logic                                   sample_valid = 1'b0;
  logic                                   sample_stall;
  logic signed [rss_pkg::SAMPLE_BITS-1:0] sample = '0;
  logic                                   result_valid;
  logic                                   result_stall = 1'b0;
  logic [rss_pkg::COUNT_W-1:0]            sample_count;
  logic signed [rss_pkg::MEAN_W-1:0]      mean_q8;
  logic [rss_pkg::DEV_W-1:0]              stddev_q8;
  logic signed [rss_pkg::SAMPLE_BITS-1:0] largest;
  logic signed [rss_pkg::SAMPLE_BITS-1:0] smallest;
  logic                                   full_res;

  // running statistics as the block should hold them
  int unsigned                            n_taken = 0;
  longint                                 running_sum = 0;
  bit [127:0]                             running_sumsq = '0;
  logic signed [rss_pkg::SAMPLE_BITS-1:0] max_seen = rss_pkg::SAMPLE_MIN;
  logic signed [rss_pkg::SAMPLE_BITS-1:0] min_seen = rss_pkg::SAMPLE_MAX;

  stats_t expected_stats[$];
  int     mismatches = 0;
  int     samples_sent = 0;
  int     results_checked = 0;
  bit     sender_gaps = 1'b1;
  bit     receiver_gaps = 1'b1;
  bit     holdoff_pending = 1'b0;
  int     holdoff_left = 0;
  int     quiet_cycles = 0;

  running_sample_statistics uut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .sample_count (sample_count),
    .mean_q8      (mean_q8),
    .stddev_q8    (stddev_q8),
    .largest      (largest),
    .smallest     (smallest),
    .full_res     (full_res)
  );

  always #10 clk = ~clk;

  // Fold one sample into the running statistics and return what the block should report.
  function automatic stats_t fold_sample(input logic signed [rss_pkg::SAMPLE_BITS-1:0] s);
    stats_t          r;
    longint          sv;
    longint          avg;
    longint unsigned mag;
    longint unsigned smag;
    bit [127:0]      nq;
    bit [127:0]      s2;
    bit [127:0]      rad;
    bit [127:0]      root;
    bit [127:0]      trial;
    bit [127:0]      quot;
    sv = s;
    r.full = 1'b0;
    avg = 0;
    quot = '0;
    if (n_taken >= rss_pkg::MAX_SAMPLES) begin
      r.full = 1'b1;
    end else begin
      mag = (sv < 0) ? -sv : sv;
      n_taken++;
      running_sum += sv;
      running_sumsq += 128'(mag) * 128'(mag);
      if (s > max_seen) max_seen = s;
      if (s < min_seen) min_seen = s;
    end
    if (n_taken != 0) begin
      smag = (running_sum < 0) ? -running_sum : running_sum;
      nq = 128'(n_taken) * running_sumsq;
      s2 = 128'(smag) * 128'(smag);
      avg = (running_sum * 256) / longint'(n_taken);
      if (s2 <= nq) begin
        rad = (nq - s2) << rss_pkg::DEV_SHIFT;
        root = '0;
        for (int b = 55; b >= 0; b--) begin
          trial = root | (128'(1) << b);
          if (trial * trial <= rad) root = trial;
        end
        quot = root / 128'(n_taken);
      end
    end
    r.count = n_taken[rss_pkg::COUNT_W-1:0];
    r.mean = avg[rss_pkg::MEAN_W-1:0];
    r.dev = quot[rss_pkg::DEV_W-1:0];
    r.largest = max_seen;
    r.smallest = min_seen;
    return r;
  endfunction

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic send_sample(input logic signed [rss_pkg::SAMPLE_BITS-1:0] v);
    while (sender_gaps && $urandom_range(99) < 25) begin
      sample_valid <= 1'b0;
      @(negedge clk);
    end
    sample_valid <= 1'b1;
    sample <= v;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
    expected_stats.insert(expected_stats.size(), fold_sample(v));
    samples_sent++;
    @(negedge clk);
  endtask

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $display("%0t: %s mismatch on result %0d: expected %0d, actual %0d",
               $time, name, results_checked, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    stats_t want;
    if (!rst && result_valid && !result_stall) begin
      if (expected_stats.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual count %0d mean %0d",
                 $time, sample_count, mean_q8);
        mismatches++;
      end else begin
        want = expected_stats.pop_front();
        check_field("sample_count", want.count, sample_count);
        check_field("mean_q8", want.mean, mean_q8);
        check_field("stddev_q8", want.dev, stddev_q8);
        check_field("largest", want.largest, largest);
        check_field("smallest", want.smallest, smallest);
        check_field("full_res", want.full, full_res);
      end
      results_checked++;
    end
  end

  // Result side: pick up a hold-off request at the rising edge, drive stall at the falling one.
  always begin
    @(posedge clk);
    if (holdoff_pending) begin
      holdoff_left = HOLDOFF_CYCLES;
      holdoff_pending = 1'b0;
    end
    @(negedge clk);
    if (holdoff_left > 0) begin
      result_stall <= 1'b1;
      holdoff_left--;
    end else begin
      result_stall <= receiver_gaps && ($urandom_range(99) < 25);
    end
  end

  always @(posedge clk) begin
    if ((sample_valid && !sample_stall) || (result_valid && !result_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic test_directed_extremes();
    logic signed [rss_pkg::SAMPLE_BITS-1:0] picks [20] = '{
      rss_pkg::SAMPLE_MIN, rss_pkg::SAMPLE_MAX, 16'sd0, -16'sd1, 16'sd1,
      rss_pkg::SAMPLE_MAX, rss_pkg::SAMPLE_MAX, rss_pkg::SAMPLE_MIN, rss_pkg::SAMPLE_MIN,
      16'sh5555, -16'sh5556, 16'sh7FFE, -16'sh7FFF,
      16'sd2, -16'sd2, 16'sd0, 16'sd0, 16'sh0100, -16'sh0100, 16'sd12345
    };
    foreach (picks[i]) send_sample(picks[i]);
  endtask

  task automatic test_random_full_range(input int n);
    repeat (n) send_sample(rss_pkg::SAMPLE_BITS'($urandom));
  endtask

  // runs of values close together, spread zero giving constant runs
  task automatic test_clustered(input int clusters, input int run);
    int base;
    int spread;
    for (int c = 0; c < clusters; c++) begin
      base = int'($urandom_range(64000)) - 32000;
      spread = $urandom_range(8);
      repeat (run)
        send_sample(rss_pkg::SAMPLE_BITS'(base + int'($urandom_range(2 * spread)) - spread));
    end
  endtask

  task automatic test_extreme_mix(input int n);
    repeat (n) begin
      case ($urandom_range(3))
        0:       send_sample(rss_pkg::SAMPLE_MIN);
        1:       send_sample(rss_pkg::SAMPLE_MAX);
        default: send_sample(rss_pkg::SAMPLE_BITS'($urandom));
      endcase
    end
  endtask

  task automatic test_back_to_back(input int n);
    sender_gaps = 1'b0;
    receiver_gaps = 1'b0;
    test_random_full_range(n);
    sender_gaps = 1'b1;
    receiver_gaps = 1'b1;
  endtask

  // hold the result side off while samples keep coming, so the block backs up
  task automatic test_receiver_holdoff(input int n);
    holdoff_pending = 1'b1;
    sender_gaps = 1'b0;
    test_random_full_range(n);
    sender_gaps = 1'b1;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed_extremes();
    test_random_full_range(540);
    test_clustered(14, 30);
    test_extreme_mix(200);
    test_back_to_back(100);
    test_receiver_holdoff(12);
    sample_valid <= 1'b0;
    wait (expected_stats.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d samples (extremes, full-range random, clustered runs, extreme mix,",
             samples_sent);
    $display("back-to-back and a held-off result side); checked %0d results.", results_checked);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/rss_pkg.sv
rtl/running_sample_statistics.sv
sim/tb_running_sample_statistics.sv
